// File: rtl/bst_pkg.sv
// Shared types, codes and default sizes of the buffer slot table.
`default_nettype none
package bst_pkg;

    localparam int MODE_W     = 2;
    localparam int BLKNUM_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int SLOT_IDX_W = 5;
    localparam int WB_BLK_W   = 13;

    localparam int SLOT_COUNT_DEF       = 32;
    localparam int DISK_BLOCK_COUNT_DEF = 8192;
    localparam int AGE_BITS_DEF         = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC  = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_MARK   = 2'd2,
        MODE_FLUSH  = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_OOB  = 2'd1,
        ST_MISS = 2'd2
    } t_status;

    typedef struct packed {
        logic accept;
        logic rd_en;
        logic chk;
        logic fin;
    } t_ctl_cmd;

    typedef struct packed {
        logic in_oob;
        logic flush_hit;
        logic out_free;
    } t_ctl_sts;

endpackage
`default_nettype wire

// File: rtl/bst_in_if.sv
// Request channel: mode and block number with valid/ready.
`default_nettype none
interface bst_in_if;
    logic                               valid;
    logic                               ready;
    logic [bst_pkg::MODE_W-1:0]         mode;
    logic signed [bst_pkg::BLKNUM_W-1:0] block_number;

    modport source (output valid, output mode, output block_number, input ready);
    modport sink   (input valid, input mode, input block_number, output ready);
endinterface
`default_nettype wire

// File: rtl/bst_out_if.sv
// Response channel: status, slot and writeback request with valid/ready.
`default_nettype none
interface bst_out_if;
    logic                             valid;
    logic                             ready;
    logic [bst_pkg::STATUS_W-1:0]     status;
    logic [bst_pkg::SLOT_IDX_W-1:0]   slot_index;
    logic                             writeback_valid;
    logic [bst_pkg::WB_BLK_W-1:0]     writeback_block;
    logic                             last_result;

    modport source (output valid, output status, output slot_index,
                    output writeback_valid, output writeback_block,
                    output last_result, input ready);
    modport sink   (input valid, input status, input slot_index,
                    input writeback_valid, input writeback_block,
                    input last_result, output ready);
endinterface
`default_nettype wire

// File: rtl/buffer_slot_table_with_replacement.sv
// Top level of the buffer slot table: sequencer plus slot datapath.
//
// Requests enter on i_req (mode, block_number) and responses leave on o_rsp,
// both valid/ready channels; an item moves when valid and ready are high at a
// rising edge of i_clk. Allocate, lookup and mark dirty give one response;
// flush gives one response per valid dirty slot in slot order, or a single
// empty response, with last_result set on the final one.
// A request that is not a flush and whose block number lies outside the disk
// skips the scan and gets an out-of-bound response from the finish step. Any
// other request walks every slot once through the age/block memory, which has
// one read and one write port, one slot per cycle while the scan is not
// stalled. One request is in work at a time and its end waits for room in the
// output register; ready returns after that edge, so a new request is taken
// only once the previous one has finished.
// A full output register stalls the scan at the next flush writeback and
// holds the end of the request; a flush whose last writeback still waits keeps
// ready low, otherwise a waiting response does not block taking the next one.
// Synchronous active-low reset frees every slot and clears the dirty bits;
// ages and block numbers sit in the memory and are written when a slot is
// taken, so the memory needs no clearing pass.
`default_nettype none
module buffer_slot_table_with_replacement #(
    parameter int SLOT_COUNT       = bst_pkg::SLOT_COUNT_DEF,
    parameter int DISK_BLOCK_COUNT = bst_pkg::DISK_BLOCK_COUNT_DEF,
    parameter int AGE_BITS         = bst_pkg::AGE_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    bst_in_if.sink     i_req,
    bst_out_if.source  o_rsp
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    bst_pkg::t_ctl_cmd ctl_cmd;
    bst_pkg::t_ctl_sts ctl_sts;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  chk_idx;
    logic              req_ready;

    assign i_req.ready = req_ready;

    bst_ctrl #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_req.valid),
        .o_ready   (req_ready),
        .i_sts     (ctl_sts),
        .o_cmd     (ctl_cmd),
        .o_rd_addr (rd_addr),
        .o_chk_idx (chk_idx)
    );

    bst_datapath #(
        .SLOT_COUNT       (SLOT_COUNT),
        .DISK_BLOCK_COUNT (DISK_BLOCK_COUNT),
        .AGE_BITS         (AGE_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (ctl_cmd),
        .i_rd_addr         (rd_addr),
        .i_chk_idx         (chk_idx),
        .o_sts             (ctl_sts),
        .i_mode            (i_req.mode),
        .i_block_number    (i_req.block_number),
        .o_valid           (o_rsp.valid),
        .i_ready           (o_rsp.ready),
        .o_status          (o_rsp.status),
        .o_slot_index      (o_rsp.slot_index),
        .o_writeback_valid (o_rsp.writeback_valid),
        .o_writeback_block (o_rsp.writeback_block),
        .o_last_result     (o_rsp.last_result)
    );

endmodule
`default_nettype wire

// File: rtl/bst_datapath.sv
// Slot flags, age/block memory, scan accumulators and result register.
`default_nettype none
module bst_datapath #(
    parameter int SLOT_COUNT       = bst_pkg::SLOT_COUNT_DEF,
    parameter int DISK_BLOCK_COUNT = bst_pkg::DISK_BLOCK_COUNT_DEF,
    parameter int AGE_BITS         = bst_pkg::AGE_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire bst_pkg::t_ctl_cmd              i_cmd,
    input  wire [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] i_rd_addr,
    input  wire [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] i_chk_idx,
    output bst_pkg::t_ctl_sts                   o_sts,
    input  wire [bst_pkg::MODE_W-1:0]           i_mode,
    input  wire signed [bst_pkg::BLKNUM_W-1:0]  i_block_number,
    output logic                                o_valid,
    input  wire                                 i_ready,
    output logic [bst_pkg::STATUS_W-1:0]        o_status,
    output logic [bst_pkg::SLOT_IDX_W-1:0]      o_slot_index,
    output logic                                o_writeback_valid,
    output logic [bst_pkg::WB_BLK_W-1:0]        o_writeback_block,
    output logic                                o_last_result
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int BLK_W = $clog2(DISK_BLOCK_COUNT);
    localparam int MEM_W = AGE_BITS + BLK_W;

    // Per-slot flags
    logic [SLOT_COUNT-1:0] r_valid;
    logic [SLOT_COUNT-1:0] r_dirty;

    // Age and block number per slot
    logic [MEM_W-1:0] r_mem [SLOT_COUNT];
    logic [MEM_W-1:0] r_rd_data;

    // Current item
    bst_pkg::t_mode     r_mode;
    logic [BLK_W-1:0]   r_blk;
    logic               r_oob;

    // Scan accumulators
    logic               r_free_hit;
    logic [IDX_W-1:0]   r_free_idx;
    logic [AGE_BITS-1:0] r_best_age;
    logic [IDX_W-1:0]   r_best_idx;
    logic [BLK_W-1:0]   r_best_blk;
    logic               r_best_dirty;
    logic               r_found;
    logic [IDX_W-1:0]   r_found_idx;
    logic               r_any;

    // Result register
    logic               r_out_valid;
    bst_pkg::t_status   r_out_status;
    logic [bst_pkg::SLOT_IDX_W-1:0] r_out_slot;
    logic               r_out_wbv;
    logic [bst_pkg::WB_BLK_W-1:0]   r_out_wbb;
    logic               r_out_last;

    logic [SLOT_COUNT-1:0] vd;
    logic [SLOT_COUNT-1:0] vd_shift;
    logic               chk_valid;
    logic               chk_dirty;
    logic [AGE_BITS-1:0] rd_age;
    logic [BLK_W-1:0]   rd_blk;
    logic [AGE_BITS-1:0] aged;
    logic               flush_last;
    logic               flush_hit;
    logic               out_free;
    logic               fin_go;
    logic [IDX_W-1:0]   pick;
    logic               evict_wb;

    logic               n_load;
    bst_pkg::t_status   n_status;
    logic [IDX_W-1:0]   n_slot;
    logic               n_wbv;
    logic [BLK_W-1:0]   n_wbb;
    logic               n_last;
    logic [31:0]        slot_ext;
    logic [31:0]        wbb_ext;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [MEM_W-1:0]   wr_data;

    assign vd         = r_valid & r_dirty;
    assign vd_shift   = vd >> i_chk_idx;
    assign flush_last = ~|(vd_shift >> 1);
    assign chk_valid  = r_valid[i_chk_idx];
    assign chk_dirty  = r_dirty[i_chk_idx];
    assign rd_age     = r_rd_data[MEM_W-1 -: AGE_BITS];
    assign rd_blk     = r_rd_data[BLK_W-1:0];
    // saturate at all ones
    assign aged       = (&rd_age) ? rd_age : rd_age + 1'b1;
    assign flush_hit  = (r_mode == bst_pkg::MODE_FLUSH) && !r_oob && vd[i_chk_idx];
    assign out_free   = !r_out_valid || i_ready;
    assign fin_go     = i_cmd.fin && out_free;
    assign pick       = r_free_hit ? r_free_idx : r_best_idx;
    assign evict_wb   = !r_free_hit && r_best_dirty;

    assign o_sts.in_oob    = (bst_pkg::t_mode'(i_mode) != bst_pkg::MODE_FLUSH) &&
                             ($unsigned(i_block_number) >= 16'(DISK_BLOCK_COUNT));
    assign o_sts.flush_hit = flush_hit;
    assign o_sts.out_free  = out_free;

    // Result selection
    always_comb begin
        n_load   = 1'b0;
        n_status = bst_pkg::ST_OK;
        n_slot   = '0;
        n_wbv    = 1'b0;
        n_wbb    = '0;
        n_last   = 1'b1;
        if (i_cmd.chk && flush_hit && out_free) begin
            n_load = 1'b1;
            n_slot = i_chk_idx;
            n_wbv  = 1'b1;
            n_wbb  = rd_blk;
            n_last = flush_last;
        end else if (fin_go) begin
            if (r_oob) begin
                n_load   = 1'b1;
                n_status = bst_pkg::ST_OOB;
            end else begin
                unique case (r_mode) inside
                    bst_pkg::MODE_ALLOC: begin
                        n_load = 1'b1;
                        n_slot = pick;
                        n_wbv  = evict_wb;
                        n_wbb  = evict_wb ? r_best_blk : '0;
                    end
                    bst_pkg::MODE_LOOKUP, bst_pkg::MODE_MARK: begin
                        n_load = 1'b1;
                        if (r_found) begin
                            n_slot = r_found_idx;
                        end else begin
                            n_status = bst_pkg::ST_MISS;
                        end
                    end
                    bst_pkg::MODE_FLUSH: begin
                        n_load = !r_any;
                    end
                endcase
            end
        end
    end

    assign slot_ext = 32'(n_slot);
    assign wbb_ext  = 32'(n_wbb);

    // Single write port: aging during the scan, new entry at the end
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = i_chk_idx;
        wr_data = {aged, rd_blk};
        if (i_cmd.chk && (r_mode == bst_pkg::MODE_ALLOC) && chk_valid) begin
            wr_en = 1'b1;
        end else if (fin_go && !r_oob && (r_mode == bst_pkg::MODE_ALLOC)) begin
            wr_en   = 1'b1;
            wr_addr = pick;
            wr_data = {{AGE_BITS{1'b0}}, r_blk};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
        end else if (fin_go && !r_oob) begin
            if (r_mode == bst_pkg::MODE_ALLOC) begin
                r_valid[pick] <= 1'b1;
                r_dirty[pick] <= 1'b0;
            end else if ((r_mode == bst_pkg::MODE_MARK) && r_found) begin
                r_dirty[r_found_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_hit <= 1'b0;
            r_found    <= 1'b0;
            r_any      <= 1'b0;
            r_oob      <= 1'b0;
            r_mode     <= bst_pkg::MODE_ALLOC;
        end else if (i_cmd.accept) begin
            r_mode       <= bst_pkg::t_mode'(i_mode);
            r_blk        <= i_block_number[BLK_W-1:0];
            r_oob        <= o_sts.in_oob;
            r_free_hit   <= 1'b0;
            r_found      <= 1'b0;
            r_any        <= 1'b0;
            r_best_age   <= '0;
            r_best_idx   <= '0;
            r_best_dirty <= 1'b0;
        end else if (i_cmd.chk) begin
            if (r_mode == bst_pkg::MODE_ALLOC) begin
                if (!chk_valid && !r_free_hit) begin
                    r_free_hit <= 1'b1;
                    r_free_idx <= i_chk_idx;
                end
                // strict compare keeps the lowest index on a tie
                if (chk_valid && (aged > r_best_age)) begin
                    r_best_age   <= aged;
                    r_best_idx   <= i_chk_idx;
                    r_best_blk   <= rd_blk;
                    r_best_dirty <= chk_dirty;
                end
            end else if (r_mode == bst_pkg::MODE_FLUSH) begin
                if (flush_hit && out_free) begin
                    r_any <= 1'b1;
                end
            end else begin
                if (chk_valid && (rd_blk == r_blk) && !r_found) begin
                    r_found     <= 1'b1;
                    r_found_idx <= i_chk_idx;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_out_status <= n_status;
            r_out_slot   <= slot_ext[bst_pkg::SLOT_IDX_W-1:0];
            r_out_wbv    <= n_wbv;
            r_out_wbb    <= wbb_ext[bst_pkg::WB_BLK_W-1:0];
            r_out_last   <= n_last;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_out_status;
    assign o_slot_index      = r_out_slot;
    assign o_writeback_valid = r_out_wbv;
    assign o_writeback_block = r_out_wbb;
    assign o_last_result     = r_out_last;

endmodule
`default_nettype wire

// File: rtl/bst_ctrl.sv
// Sequencer: accepts an item, walks the slots once unless it is out of bound, then finishes it.
`default_nettype none
module bst_ctrl #(
    parameter int SLOT_COUNT = bst_pkg::SLOT_COUNT_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    output logic                      o_ready,
    input  wire bst_pkg::t_ctl_sts    i_sts,
    output bst_pkg::t_ctl_cmd         o_cmd,
    output logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] o_rd_addr,
    output logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] o_chk_idx
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOT_COUNT - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    t_state           r_state;
    logic             r_in_ready;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_rd_live;
    logic [IDX_W-1:0] r_chk_idx;
    logic             r_chk_live;

    logic             accept;
    logic             stall;

    assign accept = i_valid && r_in_ready;
    // hold the scan while a flush result cannot be placed
    assign stall  = (r_state == S_SCAN) && r_chk_live && i_sts.flush_hit && !i_sts.out_free;

    assign o_cmd.accept = accept;
    assign o_cmd.rd_en  = (r_state == S_SCAN) && r_rd_live && !stall;
    assign o_cmd.chk    = (r_state == S_SCAN) && r_chk_live;
    assign o_cmd.fin    = (r_state == S_FIN);
    assign o_rd_addr    = r_rd_idx;
    assign o_chk_idx    = r_chk_idx;
    assign o_ready      = r_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
            r_rd_idx   <= '0;
            r_rd_live  <= 1'b0;
            r_chk_idx  <= '0;
            r_chk_live <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_in_ready <= 1'b0;
                        r_rd_idx   <= '0;
                        r_rd_live  <= 1'b1;
                        r_chk_live <= 1'b0;
                        r_state    <= i_sts.in_oob ? S_FIN : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (!stall) begin
                        r_chk_live <= r_rd_live;
                        r_chk_idx  <= r_rd_idx;
                        if (r_rd_live) begin
                            r_rd_idx  <= r_rd_idx + 1'b1;
                            r_rd_live <= (r_rd_idx != LAST);
                        end
                        if (r_chk_live && (r_chk_idx == LAST)) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    if (i_sts.out_free) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_ready |-> (r_state == S_IDLE))
        else $error("ready outside idle");

    a_accept_drops_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !r_in_ready)
        else $error("ready held after accept");

    a_fin_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && !i_sts.out_free) |=> (r_state == S_FIN))
        else $error("finish left with result register full");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_en |-> (r_rd_idx <= LAST))
        else $error("slot read past last slot");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stall |=> ($stable(r_chk_idx) && r_chk_live))
        else $error("scan advanced during stall");
`endif

endmodule
`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench for the buffer slot table: directed and random requests.
`default_nettype none
module tb_top;

    localparam int SLOTS          = bst_pkg::SLOT_COUNT_DEF;
    localparam int DISK_SIZE      = bst_pkg::DISK_BLOCK_COUNT_DEF;
    localparam int AGE_W          = bst_pkg::AGE_BITS_DEF;
    localparam int SLOT_W         = bst_pkg::SLOT_IDX_W;
    localparam int WBB_W          = bst_pkg::WB_BLK_W;
    localparam int BLKN_W         = bst_pkg::BLKNUM_W;
    localparam int RANDOM_ITEMS   = 393;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_PRINTED    = 50;

    typedef struct packed {
        bst_pkg::t_status        status;
        logic [SLOT_W-1:0]       slot_index;
        logic                    wb_valid;
        logic [WBB_W-1:0]        wb_block;
        logic                    last;
    } t_slot_rsp;

    // Slot table predictor plus the queue of responses it still owes.
    class slot_table_sb;
        bit                  slot_used  [SLOTS];
        bit                  slot_dirty [SLOTS];
        logic [AGE_W-1:0]    slot_age   [SLOTS];
        logic [WBB_W-1:0]    slot_blk   [SLOTS];
        t_slot_rsp           due_rsp_q[$];
        int errors, checked;
        int n_alloc, n_evict, n_wb, n_lookup, n_mark, n_flush, n_flush_wb, n_oob, n_miss;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                slot_used[i]  = 1'b0;
                slot_dirty[i] = 1'b0;
                slot_age[i]   = '0;
                slot_blk[i]   = '0;
            end
            errors = 0;
            checked = 0;
            n_alloc = 0; n_evict = 0; n_wb = 0; n_lookup = 0; n_mark = 0;
            n_flush = 0; n_flush_wb = 0; n_oob = 0; n_miss = 0;
        endfunction

        function void push_rsp(bst_pkg::t_status st, int slot, bit wbv,
                               logic [WBB_W-1:0] wbb, bit last);
            t_slot_rsp r;
            r.status     = st;
            r.slot_index = SLOT_W'(slot);
            r.wb_valid   = wbv;
            r.wb_block   = wbv ? wbb : '0;
            r.last       = last;
            due_rsp_q.push_back(r);
        endfunction

        function void note_request(bst_pkg::t_mode m, logic signed [BLKN_W-1:0] b);
            bit                  oob;
            logic [WBB_W-1:0]    blk;
            logic [AGE_W-1:0]    oldest;
            int                  pick, tail;
            oob  = (b < 0) || (b >= DISK_SIZE);
            blk  = b[WBB_W-1:0];
            pick = -1;
            tail = -1;
            if (m == bst_pkg::MODE_FLUSH) begin
                n_flush++;
                for (int i = 0; i < SLOTS; i++)
                    if (slot_used[i] && slot_dirty[i]) tail = i;
                if (tail < 0) begin
                    push_rsp(bst_pkg::ST_OK, 0, 1'b0, '0, 1'b1);
                end else begin
                    // dirty bits stay set after a flush
                    for (int i = 0; i <= tail; i++)
                        if (slot_used[i] && slot_dirty[i]) begin
                            push_rsp(bst_pkg::ST_OK, i, 1'b1, slot_blk[i], i == tail);
                            n_flush_wb++;
                        end
                end
            end else if (oob) begin
                n_oob++;
                push_rsp(bst_pkg::ST_OOB, 0, 1'b0, '0, 1'b1);
            end else if (m == bst_pkg::MODE_ALLOC) begin
                n_alloc++;
                for (int i = 0; i < SLOTS; i++)
                    if (slot_used[i] && slot_age[i] != {AGE_W{1'b1}}) slot_age[i]++;
                for (int i = 0; i < SLOTS; i++)
                    if (!slot_used[i] && pick < 0) pick = i;
                if (pick < 0) begin
                    // evict the oldest slot, lowest index wins a tie
                    n_evict++;
                    oldest = '0;
                    pick = 0;
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_age[i] > oldest) begin
                            oldest = slot_age[i];
                            pick = i;
                        end
                    if (slot_dirty[pick]) n_wb++;
                    push_rsp(bst_pkg::ST_OK, pick, slot_dirty[pick], slot_blk[pick], 1'b1);
                end else begin
                    push_rsp(bst_pkg::ST_OK, pick, 1'b0, '0, 1'b1);
                end
                slot_used[pick]  = 1'b1;
                slot_dirty[pick] = 1'b0;
                slot_age[pick]   = '0;
                slot_blk[pick]   = blk;
            end else begin
                if (m == bst_pkg::MODE_MARK) n_mark++;
                else n_lookup++;
                for (int i = 0; i < SLOTS; i++)
                    if (slot_used[i] && slot_blk[i] == blk && pick < 0) pick = i;
                if (pick < 0) begin
                    n_miss++;
                    push_rsp(bst_pkg::ST_MISS, 0, 1'b0, '0, 1'b1);
                end else begin
                    if (m == bst_pkg::MODE_MARK) slot_dirty[pick] = 1'b1;
                    push_rsp(bst_pkg::ST_OK, pick, 1'b0, '0, 1'b1);
                end
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("MISMATCH @%0t response %0d: %s", $time, checked, msg);
        endtask

        task check_result(t_slot_rsp got);
            t_slot_rsp want;
            checked++;
            if (due_rsp_q.size() == 0) begin
                report_mismatch("response with nothing outstanding");
            end else begin
                want = due_rsp_q.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", got.status,
                                              want.status));
                if (got.slot_index !== want.slot_index)
                    report_mismatch($sformatf("slot_index %0d, want %0d", got.slot_index,
                                              want.slot_index));
                if (got.wb_valid !== want.wb_valid)
                    report_mismatch($sformatf("writeback_valid %0b, want %0b",
                                              got.wb_valid, want.wb_valid));
                if (got.wb_block !== want.wb_block)
                    report_mismatch($sformatf("writeback_block %0d, want %0d",
                                              got.wb_block, want.wb_block));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last_result %0b, want %0b", got.last,
                                              want.last));
            end
        endtask

        function int pending();
            return due_rsp_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bst_in_if  req_if();
    bst_out_if rsp_if();

    buffer_slot_table_with_replacement dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    slot_table_sb        sb;
    bit                  no_idle;
    int                  rsp_stall_left;
    int                  idle_count;
    int unsigned         block_pool[64];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle)  return 0;
        if (r < 55)   return 0;
        if (r < 85)   return $urandom_range(1, 3);
        if (r < 97)   return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Response side: hold ready low for a random stall now and then.
    always @(negedge i_clk) begin
        if (rsp_stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall_left <= rsp_stall_left - 1;
        end else begin
            rsp_if.ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 99) < 20) rsp_stall_left <= idle_len();
        end
    end

    always @(posedge i_clk) begin
        t_slot_rsp got;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got.status     = bst_pkg::t_status'(rsp_if.status);
            got.slot_index = rsp_if.slot_index;
            got.wb_valid   = rsp_if.writeback_valid;
            got.wb_block   = rsp_if.writeback_block;
            got.last       = rsp_if.last_result;
            sb.check_result(got);
        end
    end

    // Watchdog: cycles with no item moving on either channel.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_count <= 0;
            else
                idle_count <= idle_count + 1;
            if (idle_count >= WATCHDOG_LIMIT) begin
                $display("timeout: no handshake for %0d cycles, %0d responses owed",
                         WATCHDOG_LIMIT, sb.pending());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_request(bst_pkg::t_mode m, logic signed [BLKN_W-1:0] b);
        int gap;
        gap = idle_len();
        @(negedge i_clk);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.mode         <= m;
        req_if.block_number <= b;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.note_request(m, b);
    endtask

    task automatic send_random_request();
        int                          r;
        bst_pkg::t_mode              m;
        logic signed [BLKN_W-1:0]    b;
        r = $urandom_range(0, 99);
        b = BLKN_W'(block_pool[$urandom_range(0, 63)]);
        if (r < 38)      m = bst_pkg::MODE_ALLOC;
        else if (r < 56) m = bst_pkg::MODE_LOOKUP;
        else if (r < 70) m = bst_pkg::MODE_MARK;
        else if (r < 76) begin
            m = bst_pkg::MODE_FLUSH;
            b = BLKN_W'($urandom_range(0, 65535));
        end else if (r < 88) begin
            // noise: any mode, any bit pattern, mostly out of bound
            m = bst_pkg::t_mode'($urandom_range(0, 3));
            b = BLKN_W'($urandom_range(0, 65535));
        end else begin
            m = ($urandom_range(0, 1) != 0) ? bst_pkg::MODE_LOOKUP : bst_pkg::MODE_MARK;
            b = BLKN_W'($urandom_range(0, DISK_SIZE - 1));
        end
        send_request(m, b);
    endtask

    initial begin
        sb = new();
        no_idle        = 1'b0;
        rsp_stall_left = 0;
        idle_count     = 0;
        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.mode         = bst_pkg::MODE_ALLOC;
        req_if.block_number = '0;
        rsp_if.ready        = 1'b0;
        for (int i = 0; i < 64; i++) block_pool[i] = $urandom_range(0, DISK_SIZE - 1);
        block_pool[0] = 0;
        block_pool[1] = DISK_SIZE - 1;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, bounds, duplicates and flush behavior
        send_request(bst_pkg::MODE_LOOKUP, 16'sd5);
        send_request(bst_pkg::MODE_MARK,   16'sd5);
        send_request(bst_pkg::MODE_FLUSH,  16'sd0);
        send_request(bst_pkg::MODE_ALLOC,  -16'sd1);
        send_request(bst_pkg::MODE_ALLOC,  16'sh8000);
        send_request(bst_pkg::MODE_ALLOC,  16'(DISK_SIZE));
        send_request(bst_pkg::MODE_LOOKUP, 16'sh7FFF);
        send_request(bst_pkg::MODE_MARK,   -16'sd1);
        send_request(bst_pkg::MODE_ALLOC,  16'sd0);
        send_request(bst_pkg::MODE_ALLOC,  16'(DISK_SIZE - 1));
        send_request(bst_pkg::MODE_ALLOC,  16'(DISK_SIZE - 1));
        send_request(bst_pkg::MODE_LOOKUP, 16'(DISK_SIZE - 1));
        send_request(bst_pkg::MODE_MARK,   16'(DISK_SIZE - 1));
        send_request(bst_pkg::MODE_MARK,   16'sd0);
        send_request(bst_pkg::MODE_FLUSH,  -16'sd5);
        send_request(bst_pkg::MODE_LOOKUP, 16'sd0);
        send_request(bst_pkg::MODE_FLUSH,  16'shFFFF);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // switch between bursts with no idling and idling stretches
            if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
            send_random_request();
        end
        no_idle = 1'b0;
        @(negedge i_clk);
        req_if.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SLOTS + 10) @(posedge i_clk);

        $display("covered %0d allocations (%0d evictions, %0d with writeback), %0d lookups,",
                 sb.n_alloc, sb.n_evict, sb.n_wb, sb.n_lookup);
        $display("%0d marks, %0d misses, %0d out of bound, %0d flushes (%0d writebacks);",
                 sb.n_mark, sb.n_miss, sb.n_oob, sb.n_flush, sb.n_flush_wb);
        $display("%0d responses checked", sb.checked);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
